@@ design/positional_list_store_macros.svh @@
// ----------------------------------------------------------------------------
// positional list store assertion macros
// shared property wrappers for the list store checks
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pls_pkg.sv @@
// ----------------------------------------------------------------------------
// pls_pkg
// types, codes and widths shared by the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int LEN_W = 7;
  localparam int ST_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD_HEAD = 3'd0,
    ACT_ADD_TAIL = 3'd1,
    ACT_ADD_AT   = 3'd2,
    ACT_DEL_HEAD = 3'd3,
    ACT_DEL_TAIL = 3'd4,
    ACT_DEL_AT   = 3'd5
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ design/pls_cell.sv @@
// ----------------------------------------------------------------------------
// pls_cell
// one list slot: holds a word, takes from left on insert, right on delete
// ----------------------------------------------------------------------------
module pls_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  pls_pkg::cell_ctrl_t       ctrl,
  input  logic [pls_pkg::VAL_W-1:0] left_data,
  input  logic [pls_pkg::VAL_W-1:0] right_data,
  output logic [pls_pkg::VAL_W-1:0] data,
  output logic                      hit
);
  import pls_pkg::*;

  localparam logic [POS_W-1:0] MyIdx = POS_W'(INDEX);

  logic [VAL_W-1:0] data_next;

  assign hit = (ctrl.idx == MyIdx);

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      CELL_INS: begin
        if (MyIdx > ctrl.idx) begin
          data_next = left_data;
        end else if (hit) begin
          data_next = ctrl.value;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= ctrl.idx) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ design/pls_ctrl.sv @@
// ----------------------------------------------------------------------------
// pls_ctrl
// action decode, bounds checks and element count
// ----------------------------------------------------------------------------
module pls_ctrl #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [pls_pkg::ACT_W-1:0] action,
  input  logic [pls_pkg::VAL_W-1:0] value,
  input  logic [pls_pkg::POS_W-1:0] position,
  output pls_pkg::cell_ctrl_t       cell_ctrl,
  output pls_pkg::status_t          status_next,
  output logic [pls_pkg::LEN_W-1:0] length_next,
  output logic [pls_pkg::LEN_W-1:0] length_cur
);
  import pls_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;
  logic [POS_W-1:0] idx;
  logic             is_ins;
  logic             is_del;
  logic             full;
  logic             empty;
  cell_op_t         op;

  assign length_cur = LEN_W'(count);
  assign full       = (count == CntW'(CAPACITY));
  assign empty      = (count == '0);

  always_comb begin
    idx    = '0;
    is_ins = 1'b0;
    is_del = 1'b0;
    unique case (action_t'(action))
      ACT_ADD_HEAD: is_ins = 1'b1;
      ACT_ADD_TAIL: begin
        is_ins = 1'b1;
        idx    = POS_W'(count);
      end
      ACT_ADD_AT: begin
        is_ins = 1'b1;
        idx    = position;
      end
      ACT_DEL_HEAD: is_del = 1'b1;
      ACT_DEL_TAIL: begin
        is_del = 1'b1;
        idx    = POS_W'(count) - POS_W'(1);
      end
      ACT_DEL_AT: begin
        is_del = 1'b1;
        idx    = position;
      end
      default: begin
        // unused codes leave the list alone
        idx = '0;
      end
    endcase
  end

  // full and empty checks come before the position check
  always_comb begin
    status_next = ST_OK;
    op          = CELL_HOLD;
    priority if (is_ins) begin
      if (full) begin
        status_next = ST_FULL;
      end else if (idx > POS_W'(count)) begin
        status_next = ST_BOUNDS;
      end else begin
        op = CELL_INS;
      end
    end else if (is_del) begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else if (idx >= POS_W'(count)) begin
        status_next = ST_BOUNDS;
      end else begin
        op = CELL_DEL;
      end
    end else begin
      // unused codes report ok and move nothing
      status_next = ST_OK;
      op          = CELL_HOLD;
    end
  end

  always_comb begin
    count_next = count;
    unique case (op)
      CELL_INS: count_next = count + CntW'(1);
      CELL_DEL: count_next = count - CntW'(1);
      default:  count_next = count;
    endcase
  end

  assign length_next     = LEN_W'(count_next);
  assign cell_ctrl.op    = accept ? op : CELL_HOLD;
  assign cell_ctrl.idx   = idx;
  assign cell_ctrl.value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

@@ design/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store
// bounded ordered list of signed 32-bit words with positional insert/delete
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carrying action, value, position
//   output channel: out_valid / out_stall carrying status, removed_value,
//   length
//   each input word produces exactly one output word
//   the result is registered: it appears in the cycle after the input word is taken
//   throughput: one word per cycle while the receiver does not stall;
//   every cell of the chain compares its own slot number with the target
//   index and shifts in from its left or right neighbor in the same clock,
//   so an action at any position moves the whole chain at once
//   the output register frees the input side: a new word is taken
//   whenever the output register is empty or being drained this cycle
//   receiver stall: the result word holds in the output register and
//   in_stall rises until it is taken
//   reset: the element count and out_valid clear; slot contents are not
//   cleared, slots above the count are never read
//   a full list rejects inserts, an empty list rejects deletes, and
//   out of range positions are flagged without touching the list
// ----------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [pls_pkg::ACT_W-1:0] action,
  input  logic signed [pls_pkg::VAL_W-1:0] value,
  input  logic [pls_pkg::POS_W-1:0] position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pls_pkg::ST_W-1:0]  status,
  output logic signed [pls_pkg::VAL_W-1:0] removed_value,
  output logic [pls_pkg::LEN_W-1:0] length
);
  import pls_pkg::*;

  logic             accept;
  cell_ctrl_t       cell_ctrl;
  status_t          status_next;
  logic [LEN_W-1:0] length_next;
  logic [LEN_W-1:0] length_cur;
  logic [VAL_W-1:0] slot_data [CAPACITY];
  logic [CAPACITY-1:0] slot_hit;
  logic [VAL_W-1:0] picked;
  logic [VAL_W-1:0] removed_next;

  // take a word when the output register is free or drains this cycle
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  pls_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (action),
    .value      (value),
    .position   (position),
    .cell_ctrl  (cell_ctrl),
    .status_next(status_next),
    .length_next(length_next),
    .length_cur (length_cur)
  );

  // chain of slots, slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic [VAL_W-1:0] left_in;
    logic [VAL_W-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = '0;  // head never shifts in from the left
    end else begin : g_mid_l
      assign left_in = slot_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = slot_data[i];  // last slot keeps its word
    end else begin : g_mid_r
      assign right_in = slot_data[i+1];
    end

    pls_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .left_data (left_in),
      .right_data(right_in),
      .data      (slot_data[i]),
      .hit       (slot_hit[i])
    );
  end

  // word leaving the list: the slot whose number matches the target
  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_hit[i]) begin
        picked = picked | slot_data[i];
      end
    end
  end

  assign removed_next = (cell_ctrl.op == CELL_DEL) ? picked : '0;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_value <= removed_next;
      length        <= length_next;
    end
  end

  // checks
  `PLS_ASSERT_NOW(a_len_bound, clk, rst, out_valid, length <= LEN_W'(CAPACITY), "length over capacity")
  `PLS_ASSERT_NOW(a_len_tracks, clk, rst, out_valid, length == length_cur, "length out of step with count")
  `PLS_ASSERT_NOW(a_reject_zero, clk, rst, out_valid && status != ST_OK, removed_value == '0, "rejected action returned data")
  `PLS_ASSERT_NEXT(a_result_after, clk, rst, accept, out_valid, "accepted word produced no result")

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for positional_list_store
// drives list actions through the valid/stall input channel, keeps a
// behavioral copy of the list to predict status, removed word and length
// for every accepted word, and checks each result word against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pls_pkg::*;

  localparam int LIST_DEPTH  = CAPACITY_DEFAULT;
  localparam int POS_MAX     = 64;
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake on either side
  localparam int DRAIN_WAIT  = 8;     // the result is registered, leave some slack
  localparam int RESET_LEN   = 11;
  localparam int WORDS_PER_PHASE = 490;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // expected result of one action
  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        action = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic [POS_W-1:0]        position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] removed_value;
  logic [LEN_W-1:0]        length;

  // behavioral copy of the list: element 0 is the head
  logic signed [VAL_W-1:0] model_list [LIST_DEPTH];
  int                      model_count = 0;
  list_result_t            pending_results [$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #1 clk = ~clk;

  positional_list_store #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .value        (value),
    .position     (position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .removed_value(removed_value),
    .length       (length)
  );

  // --------------------------------------------------------------------------
  // list prediction
  // applies one action to the behavioral list and returns what the block
  // should answer; the full check comes before the position check on
  // inserts, the empty check before it on deletes
  // --------------------------------------------------------------------------
  function automatic list_result_t apply_list_action(action_t act,
                                                     logic signed [VAL_W-1:0] val,
                                                     logic [POS_W-1:0] pos);
    list_result_t r;
    int           idx;
    r.status  = ST_OK;
    r.removed = '0;
    case (act)
      ACT_ADD_HEAD, ACT_ADD_TAIL, ACT_ADD_AT: begin
        if (act == ACT_ADD_HEAD) idx = 0;
        else if (act == ACT_ADD_TAIL) idx = model_count;
        else idx = int'(pos);
        if (model_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (idx > model_count) begin
          // position equal to the length appends, anything above is rejected
          r.status = ST_BOUNDS;
        end else begin
          for (int i = model_count; i > idx; i--) model_list[i] = model_list[i-1];
          model_list[idx] = val;
          model_count++;
        end
      end
      ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_AT: begin
        if (act == ACT_DEL_HEAD) idx = 0;
        else if (act == ACT_DEL_TAIL) idx = model_count - 1;
        else idx = int'(pos);
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else if (idx >= model_count) begin
          r.status = ST_BOUNDS;
        end else begin
          r.removed = model_list[idx];
          for (int i = idx; i < model_count - 1; i++) model_list[i] = model_list[i+1];
          model_count--;
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(model_count);
    return r;
  endfunction

  // mostly random words, with the signed extremes showing up often
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                 logic [VAL_W-1:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // input side
  // valid only drops while the sender idles, so back-to-back words never
  // lower and raise it in one step; the expectation is queued at the edge
  // where the word is taken
  // --------------------------------------------------------------------------
  task automatic send_word(action_t act, logic signed [VAL_W-1:0] val,
                           logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_list_action(act, val, pos));
  endtask

  // --------------------------------------------------------------------------
  // output side: check each taken result word against the oldest
  // expectation, randomize the stall, and run the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected", VAL_W'(status), '0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", VAL_W'(status), VAL_W'(want.status));
          if (removed_value !== want.removed)
            report_mismatch("removed_value", removed_value, want.removed);
          if (length !== want.length)
            report_mismatch("length", VAL_W'(length), VAL_W'(want.length));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);

      // a hung handshake on both sides ends the run
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every delete on an empty list is rejected, whatever the position;
  // an insert past the length of an empty list is out of bounds
  task automatic test_empty_list();
    send_word(ACT_DEL_HEAD, VAL_MAX, 7'd0);
    send_word(ACT_DEL_TAIL, VAL_MIN, 7'd0);
    send_word(ACT_DEL_AT, '1, POS_W'(POS_MAX));
    send_word(ACT_ADD_AT, 32'sd5, 7'd1);
  endtask

  // signed extremes, append through add at index, positions past the end
  task automatic test_bounds_and_extremes();
    send_word(ACT_ADD_HEAD, VAL_MIN, 7'd0);
    send_word(ACT_ADD_TAIL, VAL_MAX, 7'd0);
    send_word(ACT_ADD_AT, '1, 7'd1);
    send_word(ACT_ADD_AT, '0, 7'd3);                 // equal to the length: append
    send_word(ACT_ADD_AT, 32'sd9, POS_W'(POS_MAX));  // past the end
    send_word(ACT_ADD_AT, 32'sd9, 7'd5);             // one past the length
    send_word(ACT_DEL_AT, '0, 7'd4);                 // delete at the length
    send_word(ACT_DEL_AT, '0, POS_W'(POS_MAX));
    send_word(ACT_DEL_AT, '0, 7'd2);
    send_word(ACT_DEL_HEAD, '0, 7'd0);
    send_word(ACT_DEL_TAIL, '0, 7'd0);
  endtask

  // fill to capacity, then inserts are rejected as full even with a bad
  // position, and deletes still honor the bounds
  task automatic test_full_list();
    while (model_count < LIST_DEPTH)
      send_word(action_t'(ACT_ADD_HEAD + (model_count % 3)), pick_value(),
                POS_W'($urandom_range(model_count)));
    send_word(ACT_ADD_HEAD, 32'sd1, 7'd0);
    send_word(ACT_ADD_TAIL, 32'sd2, 7'd0);
    send_word(ACT_ADD_AT, 32'sd3, POS_W'(POS_MAX));
    send_word(ACT_DEL_AT, '0, POS_W'(POS_MAX));
    send_word(ACT_DEL_AT, '0, POS_W'(LIST_DEPTH - 1));
    send_word(ACT_ADD_AT, VAL_MAX, POS_W'(LIST_DEPTH - 1));
  endtask

  // random walk of the list between empty and full: mostly legal actions
  // with random content, some rejected ones, and a slice of pure noise
  task automatic test_random_traffic(int n_words, int idle_pct, int stall_pct);
    bit               growing;
    action_t          act;
    logic [POS_W-1:0] pos;
    int               pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    growing = 1'b1;
    repeat (n_words) begin
      if (model_count >= LIST_DEPTH) growing = 1'b0;
      else if (model_count == 0) growing = 1'b1;
      else if ($urandom_range(39) == 0) growing = !growing;
      pick = $urandom_range(99);
      pos  = POS_W'($urandom_range(POS_MAX));
      if (pick < 8) begin
        act = action_t'($urandom_range(ACT_DEL_AT));
      end else if ((pick < 80) == growing) begin
        act = action_t'(ACT_ADD_HEAD + $urandom_range(2));
        if (act == ACT_ADD_AT) pos = POS_W'($urandom_range(model_count));
      end else begin
        act = action_t'(ACT_DEL_HEAD + $urandom_range(2));
        if (act == ACT_DEL_AT && model_count > 0)
          pos = POS_W'($urandom_range(model_count - 1));
      end
      send_word(act, pick_value(), pos);
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_bounds_and_extremes();
    test_full_list();

    // idling phases: none, sender, receiver, both
    test_random_traffic(WORDS_PER_PHASE, 0, 0);
    test_random_traffic(WORDS_PER_PHASE, 85, 0);
    test_random_traffic(WORDS_PER_PHASE, 0, 85);
    test_random_traffic(WORDS_PER_PHASE, 17, 17);

    // drain: let every result word out, then watch for stray ones
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
